[hdl/apc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants of the area portal connectivity block.
// ----------------------------------------------------------------------------
package apc_pkg;

  // row index width at the largest supported area count
  localparam int ROW_W = 6;
  // width of one portal open-count
  localparam int CNT_W = 8;
  // width of the area fields and of the area count register
  localparam int AREA_FIELD_W = 7;
  // width of the result mask
  localparam int MASK_W = 64;

  // command codes
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_CONN  = 2'd2,
    OP_MASK  = 2'd3
  } apc_op_t;

  // read and write control of one memory
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
  } apc_mem_ctl_t;

endpackage

[hdl/apc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_if
// Valid/ready channels of the area portal connectivity block.
// ----------------------------------------------------------------------------

// command channel
interface apc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [6:0] first_area;
  logic signed [6:0] second_area;

  modport source (output valid, opcode, first_area, second_area, input ready);
  modport sink   (input valid, opcode, first_area, second_area, output ready);
endinterface

// result channel
interface apc_out_if;
  logic        valid;
  logic        ready;
  logic        connected;
  logic [63:0] area_mask;
  logic        error;

  modport source (output valid, connected, area_mask, error, input ready);
  modport sink   (input valid, connected, area_mask, error, output ready);
endinterface

// area count register write channel
interface apc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] num_areas;

  modport source (output valid, num_areas, input ready);
  modport sink   (input valid, num_areas, output ready);
endinterface

[hdl/area_portal_connectivity.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_portal_connectivity
// Portal open-counts between areas, component recompute by flood fill,
// connected and connected-mask queries.
// ----------------------------------------------------------------------------
// channel  | dir | payload                               | handshake
// in_if    | in  | opcode, first_area, second_area       | valid/ready
// out_if   | out | connected, area_mask, error           | valid/ready
// cfg_if   | in  | num_areas                             | valid/ready
//
// One item at a time. A query reads the component row of its first area;
// trivial or rejected items get their result registered on acceptance.
// Open/close does a count read-modify-write of both rows, then a flood fill:
// S_SCAN starts a component at the next unseen area, S_FRD/S_FWT read the
// count row of each visited area, and S_WR writes the mask to each member.
// An area count write starts the same flood fill.
// Reset is synchronous; count rows read as zero until first written.
// A full result register stalls acceptance of the next item.
// ----------------------------------------------------------------------------
module area_portal_connectivity #(
  parameter int MAX_AREAS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  apc_in_if.sink     in_if,
  apc_out_if.source  out_if,
  apc_cfg_if.sink    cfg_if
);

  localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int CW = apc_pkg::CNT_W;
  localparam int RW = MAX_AREAS * CW;
  localparam int FW = apc_pkg::AREA_FIELD_W;
  localparam logic [FW-1:0] MAX_A = FW'(MAX_AREAS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_UPD1 = 8'b0000_0010,
    S_UPD2 = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_FRD  = 8'b0001_0000,
    S_FWT  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_QRY  = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [FW-1:0]        num_r, num_nxt;
  apc_pkg::apc_op_t     op_r, op_nxt;
  logic [AW-1:0]        a1_r, a1_nxt, a2_r, a2_nxt;
  logic [MAX_AREAS-1:0] seen_r, seen_nxt, pend_r, pend_nxt;
  logic [MAX_AREAS-1:0] comp_r, comp_nxt, wset_r, wset_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 conn_r, conn_nxt, err_r, err_nxt;
  logic [63:0]          mask_r, mask_nxt;
  logic                 load_out;

  apc_pkg::apc_mem_ctl_t cnt_ctl, comp_ctl;
  logic [RW-1:0]         cnt_rdata, row_mod;
  logic [MAX_AREAS-1:0]  adj, comp_rdata, nmask, new_bits;
  logic [MAX_AREAS-1:0]  pe_in, pe_bit;
  logic [AW-1:0]         pe_idx, col_sel;
  logic [CW-1:0]         cnt_old, cnt_new;

  logic                  in_fire, cfg_fire, out_fire;
  apc_pkg::apc_op_t      op_in;
  logic [FW-1:0]         f1, f2;
  logic                  neg1, neg2, rng1, rng2, same;

  apc_count_mem #(.MAX_AREAS(MAX_AREAS)) u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cnt_ctl),
    .wr_data (row_mod),
    .rd_data (cnt_rdata),
    .rd_adj  (adj)
  );

  apc_comp_mem #(.MAX_AREAS(MAX_AREAS)) u_comp (
    .clk     (clk),
    .ctl     (comp_ctl),
    .wr_data (comp_r),
    .rd_data (comp_rdata)
  );

  // handshakes
  assign cfg_if.ready = (state_r == S_IDLE);
  assign in_if.ready  = (state_r == S_IDLE) && !cfg_if.valid &&
                        (!out_valid_r || out_if.ready);
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_fire     = out_valid_r && out_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.connected = conn_r;
  assign out_if.area_mask = mask_r;
  assign out_if.error     = err_r;

  // command decode
  assign op_in = apc_pkg::apc_op_t'(in_if.opcode);
  assign f1    = in_if.first_area;
  assign f2    = in_if.second_area;
  assign neg1  = f1[FW-1];
  assign neg2  = f2[FW-1];
  assign same  = (f1 == f2);
  assign rng1  = !neg1 && (f1 < num_r) && (f1 < MAX_A);
  assign rng2  = !neg2 && (f2 < num_r) && (f2 < MAX_A);

  // areas in use
  always_comb begin
    for (int i = 0; i < MAX_AREAS; i++) begin
      nmask[i] = (FW'(i) < num_r);
    end
  end

  // lowest set bit, shared by scan, visit and write-back
  always_comb begin
    unique case (state_r)
      S_SCAN:  pe_in = nmask & ~seen_r;
      S_FRD:   pe_in = pend_r;
      default: pe_in = wset_r;
    endcase
    pe_idx = '0;
    for (int i = MAX_AREAS - 1; i >= 0; i--) begin
      if (pe_in[i]) pe_idx = AW'(i);
    end
    pe_bit = pe_in & (~pe_in + 1'b1);
  end

  // saturating count update of one column of the row just read
  always_comb begin
    col_sel = (state_r == S_UPD1) ? a2_r : a1_r;
    cnt_old = cnt_rdata[col_sel*CW +: CW];
    if (op_r == apc_pkg::OP_OPEN) begin
      cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;
    end else begin
      cnt_new = (cnt_old == '0) ? cnt_old : cnt_old - 1'b1;
    end
    row_mod = cnt_rdata;
    row_mod[col_sel*CW +: CW] = cnt_new;
  end

  assign new_bits = adj & nmask & ~seen_r;

  // control
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    op_nxt    = op_r;
    a1_nxt    = a1_r;
    a2_nxt    = a2_r;
    seen_nxt  = seen_r;
    pend_nxt  = pend_r;
    comp_nxt  = comp_r;
    wset_nxt  = wset_r;
    load_out  = 1'b0;
    conn_nxt  = 1'b0;
    err_nxt   = 1'b0;
    mask_nxt  = '0;
    cnt_ctl   = '0;
    comp_ctl  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_fire) begin
          num_nxt   = cfg_if.num_areas;
          seen_nxt  = '0;
          state_nxt = S_SCAN;
        end else if (in_fire) begin
          op_nxt = op_in;
          a1_nxt = f1[AW-1:0];
          a2_nxt = f2[AW-1:0];
          unique case (op_in)
            apc_pkg::OP_OPEN, apc_pkg::OP_CLOSE: begin
              load_out = 1'b1;
              if (!same && !neg1 && !neg2) begin
                if (!rng1 || !rng2) begin
                  err_nxt = 1'b1;
                end else begin
                  cnt_ctl.rd_en  = 1'b1;
                  cnt_ctl.rd_row = apc_pkg::ROW_W'(f1[AW-1:0]);
                  state_nxt      = S_UPD1;
                end
              end
            end
            apc_pkg::OP_CONN: begin
              if (same || neg1 || neg2) begin
                load_out = 1'b1;
                conn_nxt = 1'b1;
              end else if (!rng1 || !rng2) begin
                load_out = 1'b1;
                err_nxt  = 1'b1;
              end else begin
                comp_ctl.rd_en  = 1'b1;
                comp_ctl.rd_row = apc_pkg::ROW_W'(f1[AW-1:0]);
                state_nxt       = S_QRY;
              end
            end
            default: begin
              if (neg1) begin
                load_out = 1'b1;
              end else if (!rng1) begin
                load_out = 1'b1;
                err_nxt  = 1'b1;
              end else begin
                comp_ctl.rd_en  = 1'b1;
                comp_ctl.rd_row = apc_pkg::ROW_W'(f1[AW-1:0]);
                state_nxt       = S_QRY;
              end
            end
          endcase
        end
      end
      S_UPD1: begin
        cnt_ctl.wr_en  = 1'b1;
        cnt_ctl.wr_row = apc_pkg::ROW_W'(a1_r);
        cnt_ctl.rd_en  = 1'b1;
        cnt_ctl.rd_row = apc_pkg::ROW_W'(a2_r);
        state_nxt      = S_UPD2;
      end
      S_UPD2: begin
        cnt_ctl.wr_en  = 1'b1;
        cnt_ctl.wr_row = apc_pkg::ROW_W'(a2_r);
        seen_nxt       = '0;
        state_nxt      = S_SCAN;
      end
      // next unseen area starts a component
      S_SCAN: begin
        if (pe_in == '0) begin
          state_nxt = S_IDLE;
        end else begin
          seen_nxt  = seen_r | pe_bit;
          pend_nxt  = pe_bit;
          comp_nxt  = pe_bit;
          state_nxt = S_FRD;
        end
      end
      // visit a pending area: read its count row
      S_FRD: begin
        if (pe_in == '0) begin
          wset_nxt  = comp_r;
          state_nxt = S_WR;
        end else begin
          pend_nxt       = pend_r & ~pe_bit;
          cnt_ctl.rd_en  = 1'b1;
          cnt_ctl.rd_row = apc_pkg::ROW_W'(pe_idx);
          state_nxt      = S_FWT;
        end
      end
      S_FWT: begin
        seen_nxt  = seen_r | new_bits;
        pend_nxt  = pend_r | new_bits;
        comp_nxt  = comp_r | new_bits;
        state_nxt = S_FRD;
      end
      // write the component mask to each member
      S_WR: begin
        comp_ctl.wr_en  = 1'b1;
        comp_ctl.wr_row = apc_pkg::ROW_W'(pe_idx);
        wset_nxt        = wset_r & ~pe_bit;
        if ((wset_r & ~pe_bit) == '0) begin
          state_nxt = S_SCAN;
        end
      end
      S_QRY: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          conn_nxt  = (op_r == apc_pkg::OP_CONN) && comp_rdata[a2_r];
          mask_nxt  = (op_r == apc_pkg::OP_MASK) ? 64'(comp_rdata) : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_fire ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_r       <= num_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a1_r   <= a1_nxt;
    a2_r   <= a2_nxt;
    seen_r <= seen_nxt;
    pend_r <= pend_nxt;
    comp_r <= comp_nxt;
    wset_r <= wset_nxt;
    if (load_out) begin
      conn_r <= conn_nxt;
      mask_r <= mask_nxt;
      err_r  <= err_nxt;
    end
  end

  // a rejected item carries no answer
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> !conn_r && (mask_r == '0))
    else $error("error result carries an answer");

  // an area count write starts the flood fill
  a_cfg_flood: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> state_r == S_SCAN)
    else $error("area count write did not start flood fill");

  // the flood fill never marks an area that is not in use
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRD || state_r == S_FWT || state_r == S_WR) |->
      (seen_r & ~nmask) == '0)
    else $error("flood fill reached an unused area");

  // connected and mask answers never appear together
  a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && conn_r |-> mask_r == '0)
    else $error("both answers set");

endmodule

[hdl/apc_count_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_count_mem
// Portal open-count memory, one row of counts per area, with row valid bits.
// ----------------------------------------------------------------------------
module apc_count_mem #(
  parameter int MAX_AREAS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  apc_pkg::apc_mem_ctl_t                ctl,
  input  logic [MAX_AREAS*apc_pkg::CNT_W-1:0]  wr_data,
  output logic [MAX_AREAS*apc_pkg::CNT_W-1:0]  rd_data,
  output logic [MAX_AREAS-1:0]                 rd_adj
);

  localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int RW = MAX_AREAS * apc_pkg::CNT_W;

  logic [RW-1:0]        mem [MAX_AREAS];
  logic [RW-1:0]        rdata_r;
  logic                 rvld_r;
  logic [MAX_AREAS-1:0] valid_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_row[AW-1:0]] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[ctl.rd_row[AW-1:0]];
    end
  end

  // row valid bits, a row never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_row[AW-1:0]] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvld_r <= valid_r[ctl.rd_row[AW-1:0]];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

  // adjacency: nonzero counts of the row
  always_comb begin
    for (int i = 0; i < MAX_AREAS; i++) begin
      rd_adj[i] = |rd_data[i*apc_pkg::CNT_W +: apc_pkg::CNT_W];
    end
  end

endmodule

[hdl/apc_comp_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_comp_mem
// Component memory: for each area, the mask of areas in its component.
// ----------------------------------------------------------------------------
module apc_comp_mem #(
  parameter int MAX_AREAS = 64
) (
  input  logic                  clk,
  input  apc_pkg::apc_mem_ctl_t ctl,
  input  logic [MAX_AREAS-1:0]  wr_data,
  output logic [MAX_AREAS-1:0]  rd_data
);

  localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;

  logic [MAX_AREAS-1:0] mem [MAX_AREAS];
  logic [MAX_AREAS-1:0] rdata_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_row[AW-1:0]] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[ctl.rd_row[AW-1:0]];
    end
  end

  assign rd_data = rdata_r;

endmodule
